// ===== hdl/slt_pkg.sv =====
package slt_pkg;

	// empty slot marker (ascii zero)
	localparam logic [7:0] EMPTY_MARK = 8'h30;

	// most matches one search may return
	localparam int MAX_RESULTS = 32;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// field widths
	localparam int POS_W = 6;
	localparam int VAL_W = 8;
	localparam int CNT_W = 6;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_SEARCH = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BADPOS   = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} back_state_t;

	// decoded command
	typedef struct packed {
		opcode_t          op;
		logic             pos_ok;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} cmd_t;

	// queue status seen by front and back
	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

// ===== hdl/slt_front.sv =====
module slt_front #(
	parameter int DEPTH = 32
) (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,   // position[5:0], value[13:6], zero fill
	input  logic [1:0]         s_tuser,   // opcode[1:0]
	input  slt_pkg::q_stat_t   q_stat,
	output logic               push,
	output slt_pkg::cmd_t      cmd
);
	import slt_pkg::*;

	logic [POS_W-1:0] pos;

	assign pos = s_tdata[POS_W-1:0];

	// accept while the queue has room
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	// classify the beat: opcode and position range
	always_comb begin
		cmd.op       = opcode_t'(s_tuser);
		cmd.pos_ok   = (pos != '0) && (32'(pos) <= 32'(DEPTH));
		cmd.position = pos;
		cmd.value    = s_tdata[POS_W+VAL_W-1:POS_W];
	end

endmodule

// ===== hdl/slt_queue.sv =====
module slt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  slt_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output slt_pkg::cmd_t    head,
	output slt_pkg::q_stat_t q_stat
);
	import slt_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   fill_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.valid = (fill_q != '0);
	assign q_stat.full  = (fill_q == (QAW+1)'(QDEPTH));

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/slt_back.sv =====
module slt_back #(
	parameter int DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  slt_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [23:0]   m_tdata,
	output logic [1:0]    m_tuser,
	output logic          m_tlast
);
	import slt_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int HW = $clog2(MAX_RESULTS + 1);

	back_state_t state_q, state_nxt;

	logic [VAL_W-1:0] slots_q [DEPTH];
	logic [CW-1:0]    cnt_q, cnt_nxt;
	logic [IW-1:0]    scan_q;
	logic [HW-1:0]    hits_q;
	logic [VAL_W-1:0] key_q;
	logic             pend_valid_q;
	logic [POS_W-1:0] pend_num_q;
	logic [VAL_W-1:0] pend_val_q;

	logic             m_tvalid_q;
	status_t          out_status_q;
	logic [POS_W-1:0] out_num_q;
	logic [VAL_W-1:0] out_val_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_last_q;

	logic             can_emit;
	logic [IW-1:0]    cmd_idx;
	logic [IW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;
	logic             is_full;

	logic             emit;
	status_t          o_status;
	logic [POS_W-1:0] o_num;
	logic [VAL_W-1:0] o_val;
	logic             o_last;
	logic             do_ins;
	logic             do_del;
	logic             start_scan;
	logic             scan_step;
	logic             scan_hit;
	logic             scan_done;
	logic             pend_load;

	// output register frees when empty or taken
	assign can_emit = !m_tvalid_q || m_tready;
	assign cmd_idx  = IW'(32'(cmd.position) - 32'd1);
	assign rd_addr  = (state_q == BK_SCAN) ? scan_q : cmd_idx;
	assign rd_data  = slots_q[rd_addr];
	assign is_full  = (slots_q[DEPTH-1] != EMPTY_MARK);
	assign scan_hit = (rd_data == key_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start_scan) state_nxt = BK_SCAN;
			end
			BK_SCAN: begin
				if (scan_step && scan_done) state_nxt = BK_FLUSH;
			end
			BK_FLUSH: begin
				if (can_emit) state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	// command execution and result selection
	always_comb begin
		emit       = 1'b0;
		o_status   = ST_OK;
		o_num      = '0;
		o_val      = '0;
		o_last     = 1'b1;
		cmd_pop    = 1'b0;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		start_scan = 1'b0;
		scan_step  = 1'b0;
		scan_done  = 1'b0;
		pend_load  = 1'b0;
		cnt_nxt    = cnt_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && can_emit) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_INSERT: begin
							emit = 1'b1;
							if (is_full) begin
								o_status = ST_FULL;
							end else if (!cmd.pos_ok) begin
								o_status = ST_BADPOS;
							end else begin
								do_ins  = 1'b1;
								o_num   = cmd.position;
								o_val   = cmd.value;
								cnt_nxt = cnt_q + CW'(cmd.value != EMPTY_MARK);
							end
						end
						OP_DELETE: begin
							emit = 1'b1;
							if (!cmd.pos_ok) begin
								o_status = ST_BADPOS;
							end else begin
								do_del  = 1'b1;
								o_num   = cmd.position;
								o_val   = rd_data;
								cnt_nxt = cnt_q - CW'(rd_data != EMPTY_MARK);
							end
						end
						OP_READ: begin
							emit = 1'b1;
							if (!cmd.pos_ok) begin
								o_status = ST_BADPOS;
							end else begin
								o_num = cmd.position;
								o_val = rd_data;
							end
						end
						OP_SEARCH: begin
							start_scan = 1'b1;
						end
						default: ;
					endcase
				end
			end
			BK_SCAN: begin
				// one slot per cycle while the output register is free; a match is held until the next one shows
				if (can_emit) begin
					scan_step = 1'b1;
					scan_done = (scan_q == IW'(DEPTH-1)) ||
					            (scan_hit && hits_q == HW'(MAX_RESULTS-1));
					if (scan_hit) begin
						pend_load = 1'b1;
						if (pend_valid_q) begin
							emit   = 1'b1;
							o_num  = pend_num_q;
							o_val  = pend_val_q;
							o_last = 1'b0;
						end
					end
				end
			end
			BK_FLUSH: begin
				// final match with last, or not found
				if (can_emit) begin
					emit = 1'b1;
					if (pend_valid_q) begin
						o_num = pend_num_q;
						o_val = pend_val_q;
					end else begin
						o_status = ST_NOTFOUND;
					end
				end
			end
			default: ;
		endcase
	end

	// control and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			m_tvalid_q   <= 1'b0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			scan_q       <= '0;
			hits_q       <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (start_scan) begin
				scan_q       <= '0;
				hits_q       <= '0;
				pend_valid_q <= 1'b0;
			end else if (scan_step) begin
				scan_q <= scan_q + 1'b1;
				if (scan_hit) begin
					hits_q       <= hits_q + 1'b1;
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start_scan) begin
			key_q <= cmd.value;
		end
		if (pend_load) begin
			pend_num_q <= POS_W'(32'(scan_q) + 32'd1);
			pend_val_q <= rd_data;
		end
		if (emit) begin
			out_status_q <= o_status;
			out_num_q    <= o_num;
			out_val_q    <= o_val;
			out_cnt_q    <= CNT_W'(cnt_nxt);
			out_last_q   <= o_last;
		end
	end

	// slot table: shift up on insert, down on delete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				slots_q[i] <= EMPTY_MARK;
			end
		end else if (do_ins) begin
			for (int i = DEPTH-1; i >= 1; i--) begin
				if (i > int'(cmd_idx)) slots_q[i] <= slots_q[i-1];
			end
			slots_q[cmd_idx] <= cmd.value;
		end else if (do_del) begin
			for (int i = 0; i < DEPTH-1; i++) begin
				if (i >= int'(cmd_idx)) slots_q[i] <= slots_q[i+1];
			end
			slots_q[DEPTH-1] <= EMPTY_MARK;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0, out_cnt_q, out_val_q, out_num_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== hdl/sequential_list_table_core.sv =====
// sequential list table: DEPTH byte slots numbered from 1, 0x30 marks empty
// input stream: s_tuser carries the opcode (insert, delete, read, search),
// s_tdata the position and the byte; one beat is one command
// output stream: m_tuser carries the status, m_tdata the slot number, slot
// byte and occupied count; m_tlast marks the final result beat of a command
// a front stage decodes each beat into a two-entry command queue, the back
// stage owns the table and drives a registered output beat
// with an empty queue and a free output register, a taken command beat is
// held in a queue entry and its result beat is registered in the output register
// the back stage runs insert, delete and read from its idle state; a search
// walks the table one slot per cycle through the single read port while the
// output register is free, holding the back stage through start, scan and
// final beat, and returns one match per cycle while matches follow each other
// reset: every slot holds the empty mark, queue and output are empty
// when the receiver stalls the output beat holds, the back stage pauses, the
// queue fills and s_tready drops after two more commands
module sequential_list_table_core #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // position[5:0], value[13:6], zero fill
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // slot_number[5:0], slot_value[13:6],
	                               // occupied_count[19:14], zero fill
	output logic [1:0]  m_tuser,   // status[1:0]
	output logic        m_tlast
);
	import slt_pkg::*;

	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;
	logic    push;
	logic    cmd_pop;

	slt_front #(.DEPTH(DEPTH)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (push_cmd)
	);

	slt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (cmd_pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	slt_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_stat.valid),
		.cmd       (head),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// back never pops an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> q_stat.valid)
		else $error("command popped from empty queue");

	// a full queue blocks the input side
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> (!s_tready && q_stat.valid))
		else $error("input accepted into full queue");

	// a command pushed into an empty queue is visible next cycle
	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_stat.valid) |=> q_stat.valid)
		else $error("pushed command lost");

endmodule

// ===== dv/tb_sequential_list_table_core.sv =====
module tb_sequential_list_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	import slt_pkg::*;

	localparam int TBL_DEPTH   = 32;
	localparam int N_RANDOM    = 347;
	localparam int CALM_TAIL   = 70;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_LIMIT = 500;
	localparam int REPORT_MAX  = 10;

	// one result beat as the table returns it
	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] slot_number;
		logic [VAL_W-1:0] slot_value;
		logic [CNT_W-1:0] occupied;
		logic             last;
	} table_result_t;

	// table predictor and the results it still owes
	class table_scoreboard;
		logic [VAL_W-1:0] slots [TBL_DEPTH];
		table_result_t    owed_q [$];
		int n_cmds, n_beats, n_errors, n_matches, n_full, n_badpos, n_notfound;

		function new();
			foreach (slots[i]) slots[i] = EMPTY_MARK;
			n_cmds = 0;
			n_beats = 0;
			n_errors = 0;
			n_matches = 0;
			n_full = 0;
			n_badpos = 0;
			n_notfound = 0;
		endfunction

		function int occupied();
			int n;
			n = 0;
			foreach (slots[i]) if (slots[i] != EMPTY_MARK) n++;
			return n;
		endfunction

		function void owe(status_t st, int num, logic [VAL_W-1:0] v, logic lst);
			table_result_t r;
			r.status      = st;
			r.slot_number = num[POS_W-1:0];
			r.slot_value  = v;
			r.occupied    = CNT_W'(occupied());
			r.last        = lst;
			owed_q.push_back(r);
			case (st)
				ST_FULL:     n_full++;
				ST_BADPOS:   n_badpos++;
				ST_NOTFOUND: n_notfound++;
				default:     ;
			endcase
		endfunction

		function void flag(string what, table_result_t e, table_result_t g);
			n_errors++;
			if (n_errors <= REPORT_MAX)
				$display("%0t %s: exp st=%0d num=%0d val=%h cnt=%0d last=%b, %s",
					$realtime, what, e.status, e.slot_number, e.slot_value,
					e.occupied, e.last,
					$sformatf("got st=%0d num=%0d val=%h cnt=%0d last=%b",
						g.status, g.slot_number, g.slot_value, g.occupied, g.last));
		endfunction

		// update the table for one accepted command beat
		function void note_command(opcode_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] v);
			int i;
			int idx;
			bit pos_ok;
			logic [VAL_W-1:0] removed;
			int hit_q [$];
			pos_ok = (pos >= 1) && (pos <= TBL_DEPTH);
			idx = pos_ok ? int'(pos) - 1 : 0;
			n_cmds++;
			case (op)
				OP_INSERT: begin
					// full check wins over the position check
					if (slots[TBL_DEPTH-1] != EMPTY_MARK)
						owe(ST_FULL, 0, '0, 1'b1);
					else if (!pos_ok)
						owe(ST_BADPOS, 0, '0, 1'b1);
					else begin
						for (i = TBL_DEPTH - 1; i > idx; i--) slots[i] = slots[i-1];
						slots[idx] = v;
						owe(ST_OK, int'(pos), v, 1'b1);
					end
				end
				OP_DELETE: begin
					if (!pos_ok)
						owe(ST_BADPOS, 0, '0, 1'b1);
					else begin
						removed = slots[idx];
						for (i = idx; i + 1 < TBL_DEPTH; i++) slots[i] = slots[i+1];
						slots[TBL_DEPTH-1] = EMPTY_MARK;
						owe(ST_OK, int'(pos), removed, 1'b1);
					end
				end
				OP_READ: begin
					if (!pos_ok)
						owe(ST_BADPOS, 0, '0, 1'b1);
					else
						owe(ST_OK, int'(pos), slots[idx], 1'b1);
				end
				default: begin
					// ascending scan, capped match count
					for (i = 0; i < TBL_DEPTH && hit_q.size() < MAX_RESULTS; i++)
						if (slots[i] == v) hit_q.push_back(i);
					if (hit_q.size() == 0)
						owe(ST_NOTFOUND, 0, '0, 1'b1);
					foreach (hit_q[k])
						owe(ST_OK, hit_q[k] + 1, slots[hit_q[k]], k == hit_q.size() - 1);
					n_matches += hit_q.size();
				end
			endcase
		endfunction

		// compare one result beat with the oldest owed result
		function void check_beat(logic [1:0] st, logic [23:0] data, logic lst);
			table_result_t got;
			table_result_t exp_r;
			got.status      = status_t'(st);
			got.slot_number = data[5:0];
			got.slot_value  = data[13:6];
			got.occupied    = data[19:14];
			got.last        = lst;
			n_beats++;
			if (owed_q.size() == 0) begin
				flag("unexpected beat", got, got);
			end else begin
				exp_r = owed_q.pop_front();
				if (got !== exp_r) flag("mismatch", exp_r, got);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	table_scoreboard sb = new();
	bit calm = 1'b0;
	int stall_cycles = 0;

	logic [VAL_W-1:0] value_pool [6] = '{EMPTY_MARK, 8'h41, 8'h42, 8'h00, 8'hFF, 8'h43};

	sequential_list_table_core #(
		.DEPTH(TBL_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// beat monitor on both sides
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_command(opcode_t'(s_tuser), s_tdata[5:0], s_tdata[13:6]);
			if (m_tvalid && m_tready)
				sb.check_beat(m_tuser, m_tdata, m_tlast);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles with no beat", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// result receiver with short random stalls
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// present one command beat and hold it until taken
	task automatic send_cmd(opcode_t op, int pos, logic [VAL_W-1:0] v);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, v, pos[POS_W-1:0]};
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		int n;
		int mode;
		int roll;
		int ins_pct;
		int del_pct;
		int fill;
		int pos;
		opcode_t op;
		logic [VAL_W-1:0] v;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad positions, empty mark, search edges
		send_cmd(OP_READ,   0,  8'h00);
		send_cmd(OP_READ,   1,  8'h00);
		send_cmd(OP_SEARCH, 0,  8'h41);
		send_cmd(OP_SEARCH, 0,  EMPTY_MARK);
		send_cmd(OP_INSERT, 0,  8'h11);
		send_cmd(OP_INSERT, 33, 8'h22);
		send_cmd(OP_INSERT, 63, 8'hFF);
		send_cmd(OP_INSERT, 1,  8'h00);
		send_cmd(OP_INSERT, 1,  8'hFF);
		send_cmd(OP_INSERT, 2,  EMPTY_MARK);
		send_cmd(OP_DELETE, 0,  8'h00);
		send_cmd(OP_DELETE, 63, 8'h00);
		send_cmd(OP_SEARCH, 0,  8'hFF);
		send_cmd(OP_INSERT, TBL_DEPTH, 8'hAA);
		send_cmd(OP_INSERT, 5,  8'h55);
		send_cmd(OP_INSERT, 0,  8'h55);
		send_cmd(OP_READ,   TBL_DEPTH, 8'h00);
		send_cmd(OP_SEARCH, 0,  8'hAA);
		send_cmd(OP_DELETE, TBL_DEPTH, 8'h00);
		send_cmd(OP_DELETE, 1,  8'h00);
		send_cmd(OP_READ,   33, 8'h00);
		send_cmd(OP_DELETE, 1,  8'h00);
		send_cmd(OP_SEARCH, 0,  EMPTY_MARK);

		// random: fill, drain and mixed phases over the table
		mode = 0;
		for (n = 0; n < N_RANDOM; n++) begin
			if (n % 40 == 0) mode = $urandom_range(0, 2);
			if (n >= N_RANDOM - CALM_TAIL) calm = 1'b1;
			case (mode)
				0:       begin ins_pct = 55; del_pct = 15; end
				1:       begin ins_pct = 15; del_pct = 55; end
				default: begin ins_pct = 30; del_pct = 30; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				op = OP_INSERT;
			else if (roll < ins_pct + del_pct)
				op = OP_DELETE;
			else if (roll < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2)
				op = OP_READ;
			else
				op = OP_SEARCH;

			// mostly positions near the filled part, some anywhere, some bad
			fill = sb.occupied();
			roll = $urandom_range(0, 99);
			if (roll < 85)
				pos = $urandom_range(1, (fill + 1 > TBL_DEPTH) ? TBL_DEPTH : fill + 1);
			else if (roll < 92)
				pos = $urandom_range(1, TBL_DEPTH);
			else if (roll < 95)
				pos = 0;
			else
				pos = $urandom_range(TBL_DEPTH + 1, 63);

			// values from a small pool so searches hit, or any byte
			roll = $urandom_range(0, 99);
			if (op == OP_SEARCH && roll < 60)
				v = sb.slots[$urandom_range(0, TBL_DEPTH - 1)];
			else if (roll < 50)
				v = value_pool[$urandom_range(0, 5)];
			else
				v = VAL_W'($urandom_range(0, 255));

			send_cmd(op, pos, v);
		end
		s_tvalid <= 1'b0;

		// drain, then watch for stray beats
		while (sb.owed_q.size() != 0 && stall_cycles < DRAIN_LIMIT) @(posedge clk);
		repeat (2 * TBL_DEPTH + 8) @(posedge clk);
		while (sb.owed_q.size() != 0)
			sb.flag("missing beat", sb.owed_q.pop_front(), '0);

		$display("ran %0d commands, checked %0d result beats", sb.n_cmds, sb.n_beats);
		$display("search matches %0d, misses %0d, full refusals %0d, bad positions %0d",
			sb.n_matches, sb.n_notfound, sb.n_full, sb.n_badpos);
		if (sb.n_errors == 0)
			$display("PASS");
		else begin
			$display("%0d errors", sb.n_errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sequential_list_table_core.f =====
hdl/slt_pkg.sv
hdl/slt_front.sv
hdl/slt_queue.sv
hdl/slt_back.sv
hdl/sequential_list_table_core.sv
dv/tb_sequential_list_table_core.sv
